/* sv/rcmix_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rcmix_pkg;

   // Input transaction: edge report or update request.
   typedef struct packed {
      logic [1:0]  mode;
      logic        pin_level;
      logic [31:0] time_us;
   } req_type;

   // Result transaction: one per update request.
   typedef struct packed {
      logic               valid_res;
      logic [1:0]         status;
      logic signed [23:0] left_wheel;
      logic signed [23:0] right_wheel;
   } rsp_type;

   localparam logic [1:0] MODE_THROTTLE = 2'd0;
   localparam logic [1:0] MODE_STEER    = 2'd1;
   localparam logic [1:0] MODE_UPDATE   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_LOST  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam int PADDR_W = 5;

   localparam logic [2:0] REG_TARGET_SPAN  = 3'd0;
   localparam logic [2:0] REG_MAX_SPEED    = 3'd1;
   localparam logic [2:0] REG_DEAD_ZONE    = 3'd2;
   localparam logic [2:0] REG_RAMP_LINEAR  = 3'd3;
   localparam logic [2:0] REG_RAMP_TURN    = 3'd4;
   localparam logic [2:0] REG_MIX_GAIN     = 3'd5;
   localparam logic [2:0] REG_LOSS_TIMEOUT = 3'd6;

   localparam logic [14:0] RST_TARGET_SPAN  = 15'd1000;
   localparam logic [14:0] RST_MAX_SPEED    = 15'd1000;
   localparam logic [14:0] RST_DEAD_ZONE    = 15'd20;
   localparam logic [14:0] RST_RAMP_LINEAR  = 15'd10;
   localparam logic [14:0] RST_RAMP_TURN    = 15'd10;
   localparam logic [15:0] RST_MIX_GAIN     = 16'd256;
   localparam logic [31:0] RST_LOSS_TIMEOUT = 32'd100000;

   localparam int WIDTH_MIN  = 900;
   localparam int WIDTH_MAX  = 2100;
   localparam int WIDTH_IDLE = 1500;
   localparam int MAP_LOW    = 1000;
   localparam int MAP_DIV    = 1000;

   localparam int TIME_BITS_DEFAULT        = 32;
   localparam int FILTER_FRAC_BITS_DEFAULT = 16;

   // Shared datapath sizes.
   localparam int MUL_B_W = 25;
   localparam int DIV_N_W = 55;
   localparam int DIV_D_W = 32;

endpackage

`default_nettype wire

/* sv/rcmix_divider.sv */
`timescale 1ns / 1ps
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module rcmix_divider #(
   parameter int N_W = rcmix_pkg::DIV_N_W,
   parameter int D_W = rcmix_pkg::DIV_D_W
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [N_W-1:0] dividend,
   input  wire logic [D_W-1:0] divisor,
   output logic                done,
   output logic [N_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;
   logic [D_W:0]     trial_diff;

   assign trial      = {rem_ff, quo_ff[N_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(N_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial_diff[D_W]) begin
            rem_in = trial_diff[D_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[D_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* sv/rc_pwm_skid_steer_mixer_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-channel RC pulse capture and skid-steer drive mixer. Edge transactions (throttle
// or steering, rising or falling) are absorbed in the cycle they are accepted and produce
// no result. An update transaction produces exactly one result: it first checks link loss
// on both channels and the pulse width range, and a failed check returns the held wheel
// targets with a nonzero status and changes no state. A good update smooths each width
// with an alpha 0.30 moving average, maps it to a signed command, applies deadband,
// clamp and ramp, mixes to left and right wheel targets in signed Q8, and scales both
// down in proportion when a wheel exceeds the speed limit. All multiplies share one
// multiplier. The map's division by 1000 is a shift by three followed by a reciprocal
// multiply for 125 on that same multiplier. Only the wheel scaling step divides by a
// variable, and it uses a bit-serial divider that produces one quotient bit per cycle.
// A good update without scaling runs the check, then for each channel the filter
// multiply and accumulate, the map multiply, the reciprocal multiply and the shaping,
// then ramp, turn multiply and mix, and then delivery. When the scaling step runs,
// each wheel adds a multiply, a divider start and the divider work for 55 quotient
// bits. A failed update goes from the check straight to delivery. An update waits in
// its delivery state while the previous result has not been taken. The block takes no
// new transaction while an update is in progress.
// Registers are written over the APB-style port and should only be changed while the
// block is idle.
module rc_pwm_skid_steer_mixer_core #(
   parameter int TIME_BITS        = rcmix_pkg::TIME_BITS_DEFAULT,
   parameter int FILTER_FRAC_BITS = rcmix_pkg::FILTER_FRAC_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire rcmix_pkg::req_type             req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output rcmix_pkg::rsp_type                  rsp_payload,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [rcmix_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [31:0]                    pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int T   = TIME_BITS;
   localparam int F   = FILTER_FRAC_BITS;
   localparam int CW  = (T > 32) ? T : 32;
   // Smoothed width holds up to 2100 with F fraction bits.
   localparam int SW  = F + 12;
   localparam int AW  = (F + 14 > 34) ? F + 14 : 34;
   localparam int BW  = rcmix_pkg::MUL_B_W;
   localparam int PW  = AW + BW;
   localparam int NW  = rcmix_pkg::DIV_N_W;
   localparam int DW  = rcmix_pkg::DIV_D_W;

   localparam logic signed [BW-1:0] ALPHA = BW'(((3 << F) + 5) / 10);
   localparam logic [PW-1:0] HALF_P = {{(PW-1){1'b0}}, 1'b1} << (F - 1);
   localparam logic [SW:0]   HALF_S = {{SW{1'b0}}, 1'b1} << (F - 1);
   localparam logic [SW-1:0] SMOOTH_RST = SW'(rcmix_pkg::WIDTH_IDLE) << F;

   // The map divides a magnitude below 2^27 by 1000: a shift by three, then a multiply
   // by the rounded-up reciprocal of 125, which is exact over that whole range.
   localparam int MAP_PRE_SHIFT = 3;
   localparam int MAP_ODD       = rcmix_pkg::MAP_DIV >> MAP_PRE_SHIFT;
   localparam int MAP_SHIFT     = 30;
   localparam logic signed [BW-1:0] MAP_RECIP =
      BW'(((1 << MAP_SHIFT) + MAP_ODD - 1) / MAP_ODD);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_FMUL,
      S_FACC,
      S_MMUL,
      S_MDIV,
      S_SHAPE,
      S_RAMP,
      S_TMUL,
      S_MIX,
      S_NMUL,
      S_NDIV_GO,
      S_NDIV_WAIT,
      S_DELIVER
   } state_type;

   state_type state_ff, state_in;
   logic      ch_ff, ch_in;
   logic      side_ff, side_in;
   logic      neg_ff, neg_in;
   logic [1:0] status_ff, status_in;
   logic [T-1:0] now_ff, now_in;

   logic [14:0] span_ff, span_in;
   logic [14:0] max_speed_ff, max_speed_in;
   logic [14:0] dead_zone_ff, dead_zone_in;
   logic [14:0] step_lin_ff, step_lin_in;
   logic [14:0] step_turn_ff, step_turn_in;
   logic [15:0] mix_gain_ff, mix_gain_in;
   logic [31:0] timeout_ff, timeout_in;

   logic [T-1:0] rise_t_ff, rise_t_in, rise_s_ff, rise_s_in;
   logic [T-1:0] width_t_ff, width_t_in, width_s_ff, width_s_in;
   logic [T-1:0] last_t_ff, last_t_in, last_s_ff, last_s_in;
   logic [SW-1:0] smooth_t_ff, smooth_t_in, smooth_s_ff, smooth_s_in;

   logic [11:0]           w_ff, w_in;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [15:0]    tgt_t_ff, tgt_t_in, tgt_s_ff, tgt_s_in;
   logic signed [15:0]    ramp_lin_ff, ramp_lin_in, ramp_turn_ff, ramp_turn_in;
   logic signed [33:0]    left_ff, left_in, right_ff, right_in;
   logic [31:0]           mag_ff, mag_in;
   logic signed [23:0]    held_left_ff, held_left_in, held_right_ff, held_right_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rcmix_pkg::rsp_type    rsp_ff, rsp_in;

   // Shared arithmetic and helpers.
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic                 div_start;
   logic [DW-1:0]        div_divisor;
   logic                 div_done;
   logic [NW-1:0]        div_quo;
   logic [PW-1:0]        prod_mag;

   logic         cfg_wr;
   logic [2:0]   cfg_idx;
   logic [T-1:0] req_now;
   logic [T-1:0] age_t, age_s;
   logic         lost, range_bad;

   logic [11:0]          raw_sel;
   logic [SW-1:0]        sm_sel;
   logic signed [AW-1:0] diff;
   logic signed [PW-1:0] rnd, inc;
   logic signed [AW-1:0] sum_sm;
   logic [SW-1:0]        new_sm;
   logic [SW:0]          filt_sum;
   logic [11:0]          filt_w;
   logic signed [12:0]   wd;

   logic [19:0]          q20;
   logic signed [19:0]   qs, v, vmag, dz20, lim20;
   logic signed [19:0]   shaped;

   logic signed [33:0]   lin8, turn34, left_c, right_c, absl, absr;
   logic [31:0]          mag_c;
   logic [22:0]          lim_q;
   logic                 over;
   logic signed [23:0]   scaled;

   function automatic logic signed [15:0] ramp_f(input logic signed [15:0] cur,
                                                 input logic signed [15:0] tgt,
                                                 input logic [14:0] step);
      logic signed [17:0] up;
      logic signed [17:0] dn;
      logic signed [15:0] res;
      up  = 18'(cur) + $signed({3'b000, step});
      dn  = 18'(cur) - $signed({3'b000, step});
      res = cur;
      if (cur < tgt) begin
         res = (up > 18'(tgt)) ? tgt : up[15:0];
      end else if (cur > tgt) begin
         res = (dn < 18'(tgt)) ? tgt : dn[15:0];
      end
      return res;
   endfunction

   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[rcmix_pkg::PADDR_W-1:2];
   assign req_now = T'(req_payload.time_us);

   // Link loss: age of the last falling edge against the timeout, modulo the time width.
   assign age_t     = now_ff - last_t_ff;
   assign age_s     = now_ff - last_s_ff;
   assign lost      = (CW'(age_t) > CW'(timeout_ff)) || (CW'(age_s) > CW'(timeout_ff));
   assign range_bad = (width_t_ff < T'(rcmix_pkg::WIDTH_MIN)) ||
                      (width_t_ff > T'(rcmix_pkg::WIDTH_MAX)) ||
                      (width_s_ff < T'(rcmix_pkg::WIDTH_MIN)) ||
                      (width_s_ff > T'(rcmix_pkg::WIDTH_MAX));

   // Moving average of the channel selected by ch_ff.
   assign raw_sel  = ch_ff ? width_s_ff[11:0] : width_t_ff[11:0];
   assign sm_sel   = ch_ff ? smooth_s_ff : smooth_t_ff;
   assign diff     = $signed(AW'({raw_sel, {F{1'b0}}})) - $signed(AW'(sm_sel));
   assign rnd      = prod_ff + $signed(HALF_P);
   assign inc      = rnd >>> F;
   assign sum_sm   = $signed(AW'(sm_sel)) + inc[AW-1:0];
   assign new_sm   = sum_sm[SW-1:0];
   assign filt_sum = {1'b0, new_sm} + HALF_S;
   assign filt_w   = 12'(filt_sum >> F);
   assign wd       = $signed({1'b0, w_ff}) - $signed(13'(rcmix_pkg::MAP_LOW));

   // Map result, deadband and clamp. The quotient magnitude sits above the reciprocal's
   // fraction bits, and the sign is put back so the division truncates toward zero.
   assign q20   = prod_ff[MAP_SHIFT+19:MAP_SHIFT];
   assign qs    = neg_ff ? -$signed(q20) : $signed(q20);
   assign v     = qs - $signed({5'b00000, span_ff});
   assign vmag  = v[19] ? -v : v;
   assign dz20  = $signed({5'b00000, dead_zone_ff});
   assign lim20 = $signed({5'b00000, max_speed_ff});

   always_comb begin
      shaped = v;
      if (vmag < dz20) begin
         shaped = '0;
      end
      if (shaped > lim20) begin
         shaped = lim20;
      end else if (shaped < -lim20) begin
         shaped = -lim20;
      end
   end

   // Skid-steer mix in Q8.
   assign lin8    = $signed(34'(ramp_lin_ff)) <<< 8;
   assign turn34  = $signed(prod_ff[33:0]);
   assign left_c  = lin8 + turn34;
   assign right_c = lin8 - turn34;
   assign absl    = left_c[33] ? -left_c : left_c;
   assign absr    = right_c[33] ? -right_c : right_c;
   assign mag_c   = (absr[31:0] > absl[31:0]) ? absr[31:0] : absl[31:0];
   assign lim_q   = {max_speed_ff, 8'h00};
   assign over    = mag_c > 32'(lim_q);
   assign scaled  = neg_ff ? -$signed(div_quo[23:0]) : $signed(div_quo[23:0]);

   assign prod_mag = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      side_in       = side_ff;
      neg_in        = neg_ff;
      status_in     = status_ff;
      now_in        = now_ff;
      span_in       = span_ff;
      max_speed_in  = max_speed_ff;
      dead_zone_in  = dead_zone_ff;
      step_lin_in   = step_lin_ff;
      step_turn_in  = step_turn_ff;
      mix_gain_in   = mix_gain_ff;
      timeout_in    = timeout_ff;
      rise_t_in     = rise_t_ff;
      rise_s_in     = rise_s_ff;
      width_t_in    = width_t_ff;
      width_s_in    = width_s_ff;
      last_t_in     = last_t_ff;
      last_s_in     = last_s_ff;
      smooth_t_in   = smooth_t_ff;
      smooth_s_in   = smooth_s_ff;
      w_in          = w_ff;
      prod_in       = prod_ff;
      tgt_t_in      = tgt_t_ff;
      tgt_s_in      = tgt_s_ff;
      ramp_lin_in   = ramp_lin_ff;
      ramp_turn_in  = ramp_turn_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mag_in        = mag_ff;
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;
      div_divisor   = mag_ff;

      if (cfg_wr) begin
         case (cfg_idx)
            rcmix_pkg::REG_TARGET_SPAN:  span_in      = pwdata[14:0];
            rcmix_pkg::REG_MAX_SPEED:    max_speed_in = pwdata[14:0];
            rcmix_pkg::REG_DEAD_ZONE:    dead_zone_in = pwdata[14:0];
            rcmix_pkg::REG_RAMP_LINEAR:  step_lin_in  = pwdata[14:0];
            rcmix_pkg::REG_RAMP_TURN:    step_turn_in = pwdata[14:0];
            rcmix_pkg::REG_MIX_GAIN:     mix_gain_in  = pwdata[15:0];
            rcmix_pkg::REG_LOSS_TIMEOUT: timeout_in   = pwdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_payload.mode)
                  rcmix_pkg::MODE_THROTTLE: begin
                     if (req_payload.pin_level) begin
                        rise_t_in = req_now;
                     end else begin
                        width_t_in = req_now - rise_t_ff;
                        last_t_in  = req_now;
                     end
                  end
                  rcmix_pkg::MODE_STEER: begin
                     if (req_payload.pin_level) begin
                        rise_s_in = req_now;
                     end else begin
                        width_s_in = req_now - rise_s_ff;
                        last_s_in  = req_now;
                     end
                  end
                  rcmix_pkg::MODE_UPDATE: begin
                     now_in   = req_now;
                     state_in = S_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            if (lost) begin
               status_in = rcmix_pkg::STATUS_LOST;
               state_in  = S_DELIVER;
            end else if (range_bad) begin
               status_in = rcmix_pkg::STATUS_RANGE;
               state_in  = S_DELIVER;
            end else begin
               ch_in    = 1'b0;
               state_in = S_FMUL;
            end
         end
         S_FMUL: begin
            mul_a    = diff;
            mul_b    = ALPHA;
            prod_in  = mul_a * mul_b;
            state_in = S_FACC;
         end
         S_FACC: begin
            if (ch_ff) begin
               smooth_s_in = new_sm;
            end else begin
               smooth_t_in = new_sm;
            end
            w_in     = filt_w;
            state_in = S_MMUL;
         end
         S_MMUL: begin
            mul_a    = AW'(wd);
            mul_b    = $signed(BW'({span_ff, 1'b0}));
            prod_in  = mul_a * mul_b;
            state_in = S_MDIV;
         end
         S_MDIV: begin
            mul_a    = $signed(AW'(prod_mag >> MAP_PRE_SHIFT));
            mul_b    = MAP_RECIP;
            prod_in  = mul_a * mul_b;
            neg_in   = prod_ff[PW-1];
            state_in = S_SHAPE;
         end
         S_SHAPE: begin
            if (ch_ff) begin
               tgt_s_in = shaped[15:0];
               state_in = S_RAMP;
            end else begin
               tgt_t_in = shaped[15:0];
               ch_in    = 1'b1;
               state_in = S_FMUL;
            end
         end
         S_RAMP: begin
            ramp_lin_in  = ramp_f(ramp_lin_ff, tgt_t_ff, step_lin_ff);
            ramp_turn_in = ramp_f(ramp_turn_ff, tgt_s_ff, step_turn_ff);
            state_in     = S_TMUL;
         end
         S_TMUL: begin
            mul_a    = AW'(ramp_turn_ff);
            mul_b    = $signed(BW'(mix_gain_ff));
            prod_in  = mul_a * mul_b;
            state_in = S_MIX;
         end
         S_MIX: begin
            left_in   = left_c;
            right_in  = right_c;
            mag_in    = mag_c;
            status_in = rcmix_pkg::STATUS_OK;
            if (over) begin
               side_in  = 1'b0;
               state_in = S_NMUL;
            end else begin
               held_left_in  = left_c[23:0];
               held_right_in = right_c[23:0];
               state_in      = S_DELIVER;
            end
         end
         S_NMUL: begin
            mul_a    = AW'(side_ff ? right_ff : left_ff);
            mul_b    = $signed(BW'(lim_q));
            prod_in  = mul_a * mul_b;
            state_in = S_NDIV_GO;
         end
         S_NDIV_GO: begin
            div_start = 1'b1;
            neg_in    = prod_ff[PW-1];
            state_in  = S_NDIV_WAIT;
         end
         S_NDIV_WAIT: begin
            if (div_done) begin
               if (side_ff) begin
                  held_right_in = scaled;
                  state_in      = S_DELIVER;
               end else begin
                  held_left_in = scaled;
                  side_in      = 1'b1;
                  state_in     = S_NMUL;
               end
            end
         end
         S_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.valid_res   = (status_ff == rcmix_pkg::STATUS_OK);
               rsp_in.status      = status_ff;
               rsp_in.left_wheel  = held_left_ff;
               rsp_in.right_wheel = held_right_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ch_ff         <= 1'b0;
         side_ff       <= 1'b0;
         status_ff     <= rcmix_pkg::STATUS_OK;
         rsp_valid_ff  <= 1'b0;
         span_ff       <= rcmix_pkg::RST_TARGET_SPAN;
         max_speed_ff  <= rcmix_pkg::RST_MAX_SPEED;
         dead_zone_ff  <= rcmix_pkg::RST_DEAD_ZONE;
         step_lin_ff   <= rcmix_pkg::RST_RAMP_LINEAR;
         step_turn_ff  <= rcmix_pkg::RST_RAMP_TURN;
         mix_gain_ff   <= rcmix_pkg::RST_MIX_GAIN;
         timeout_ff    <= rcmix_pkg::RST_LOSS_TIMEOUT;
         rise_t_ff     <= '0;
         rise_s_ff     <= '0;
         width_t_ff    <= '0;
         width_s_ff    <= '0;
         last_t_ff     <= '0;
         last_s_ff     <= '0;
         smooth_t_ff   <= SMOOTH_RST;
         smooth_s_ff   <= SMOOTH_RST;
         ramp_lin_ff   <= '0;
         ramp_turn_ff  <= '0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
      end else begin
         state_ff      <= state_in;
         ch_ff         <= ch_in;
         side_ff       <= side_in;
         status_ff     <= status_in;
         rsp_valid_ff  <= rsp_valid_in;
         span_ff       <= span_in;
         max_speed_ff  <= max_speed_in;
         dead_zone_ff  <= dead_zone_in;
         step_lin_ff   <= step_lin_in;
         step_turn_ff  <= step_turn_in;
         mix_gain_ff   <= mix_gain_in;
         timeout_ff    <= timeout_in;
         rise_t_ff     <= rise_t_in;
         rise_s_ff     <= rise_s_in;
         width_t_ff    <= width_t_in;
         width_s_ff    <= width_s_in;
         last_t_ff     <= last_t_in;
         last_s_ff     <= last_s_in;
         smooth_t_ff   <= smooth_t_in;
         smooth_s_ff   <= smooth_s_in;
         ramp_lin_ff   <= ramp_lin_in;
         ramp_turn_ff  <= ramp_turn_in;
         held_left_ff  <= held_left_in;
         held_right_ff <= held_right_in;
      end
      neg_ff   <= neg_in;
      now_ff   <= now_in;
      w_ff     <= w_in;
      prod_ff  <= prod_in;
      tgt_t_ff <= tgt_t_in;
      tgt_s_ff <= tgt_s_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      mag_ff   <= mag_in;
      rsp_ff   <= rsp_in;
   end

   // The wheel scaling step divides by the larger wheel magnitude through this unit.
   rcmix_divider #(
      .N_W (NW),
      .D_W (DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag[NW-1:0]),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      case (cfg_idx)
         rcmix_pkg::REG_TARGET_SPAN:  prdata = 32'(span_ff);
         rcmix_pkg::REG_MAX_SPEED:    prdata = 32'(max_speed_ff);
         rcmix_pkg::REG_DEAD_ZONE:    prdata = 32'(dead_zone_ff);
         rcmix_pkg::REG_RAMP_LINEAR:  prdata = 32'(step_lin_ff);
         rcmix_pkg::REG_RAMP_TURN:    prdata = 32'(step_turn_ff);
         rcmix_pkg::REG_MIX_GAIN:     prdata = 32'(mix_gain_ff);
         rcmix_pkg::REG_LOSS_TIMEOUT: prdata = timeout_ff;
         default:                     prdata = '0;
      endcase
   end

   assign pready      = 1'b1;
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* tb/tb_rc_pwm_skid_steer_mixer_core.sv */
`timescale 1ns / 1ps

// Top level of the mixer regression. An initial block builds each phase as a queue of
// pending transactions. A clocked driver presents them on the request channel with random
// gaps. A clocked monitor takes results with random stalls and checks every field
// against the mixer model in this file. Registers are written over the APB-style port only
// while the block is idle.
module tb_rc_pwm_skid_steer_mixer_core;

   localparam int FRAC = rcmix_pkg::FILTER_FRAC_BITS_DEFAULT;
   localparam longint ALPHA = ((64'sd3 <<< FRAC) + 5) / 10;
   localparam longint HALF = 64'sd1 <<< (FRAC - 1);
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   rcmix_pkg::req_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   rcmix_pkg::rsp_type rsp_payload;
   logic psel;
   logic penable;
   logic pwrite;
   logic [rcmix_pkg::PADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   rc_pwm_skid_steer_mixer_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Model copy of the registers and the mixer state.
   longint span_r, speed_r, dead_r, step_lin_r, step_turn_r, gain_r, timeout_r;
   logic [31:0] rise_thr, rise_str, wid_thr, wid_str, last_thr, last_str;
   longint smooth_thr, smooth_str, ramp_lin, ramp_trn, held_l, held_r;

   rcmix_pkg::req_type pending_reqs[$];
   rcmix_pkg::rsp_type wheel_results[$];
   int errors = 0;
   int updates_ok = 0;
   int updates_failed = 0;
   int idle_cycles = 0;
   int n_accepted = 0;

   // Half the time no gap, otherwise mostly a short one and now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic longint floor_shr(longint v);
      if (v >= 0) return v >>> FRAC;
      return -((-v + (64'sd1 <<< FRAC) - 1) >>> FRAC);
   endfunction

   function automatic longint smooth_width(ref longint acc, input logic [31:0] raw);
      longint diff;
      diff = (longint'({32'd0, raw}) <<< FRAC) - acc;
      acc = acc + floor_shr(ALPHA * diff + HALF);
      return floor_shr(acc + HALF);
   endfunction

   function automatic longint shape_cmd(longint w);
      longint v, mag;
      v = (w - rcmix_pkg::MAP_LOW) * (2 * span_r) / rcmix_pkg::MAP_DIV - span_r;
      mag = (v < 0) ? -v : v;
      if (mag < dead_r) v = 0;
      if (v > speed_r) v = speed_r;
      if (v < -speed_r) v = -speed_r;
      return v;
   endfunction

   function automatic longint slew(longint cur, longint tgt, longint step);
      if (cur < tgt) begin
         cur = cur + step;
         if (cur > tgt) cur = tgt;
      end else if (cur > tgt) begin
         cur = cur - step;
         if (cur < tgt) cur = tgt;
      end
      return cur;
   endfunction

   function automatic void model_reset();
      span_r = rcmix_pkg::RST_TARGET_SPAN; speed_r = rcmix_pkg::RST_MAX_SPEED;
      dead_r = rcmix_pkg::RST_DEAD_ZONE;
      step_lin_r = rcmix_pkg::RST_RAMP_LINEAR; step_turn_r = rcmix_pkg::RST_RAMP_TURN;
      gain_r = rcmix_pkg::RST_MIX_GAIN; timeout_r = rcmix_pkg::RST_LOSS_TIMEOUT;
      rise_thr = '0; rise_str = '0; wid_thr = '0; wid_str = '0;
      last_thr = '0; last_str = '0;
      smooth_thr = longint'(rcmix_pkg::WIDTH_IDLE) <<< FRAC;
      smooth_str = longint'(rcmix_pkg::WIDTH_IDLE) <<< FRAC;
      ramp_lin = 0; ramp_trn = 0; held_l = 0; held_r = 0;
   endfunction

   // Applies one accepted transaction to the model and, for an update, queues the expected result.
   function automatic void mix_predict(rcmix_pkg::req_type t);
      rcmix_pkg::rsp_type r;
      longint thr, str, lim, turn, lft, rgt, ml, mr, mag;
      if (t.mode == rcmix_pkg::MODE_THROTTLE) begin
         if (t.pin_level) rise_thr = t.time_us;
         else begin
            wid_thr = t.time_us - rise_thr;
            last_thr = t.time_us;
         end
         return;
      end
      if (t.mode == rcmix_pkg::MODE_STEER) begin
         if (t.pin_level) rise_str = t.time_us;
         else begin
            wid_str = t.time_us - rise_str;
            last_str = t.time_us;
         end
         return;
      end
      if (t.mode != rcmix_pkg::MODE_UPDATE) return;
      r.valid_res = 1'b0;
      if (longint'(32'(t.time_us - last_thr)) > timeout_r
          || longint'(32'(t.time_us - last_str)) > timeout_r) begin
         r.status = rcmix_pkg::STATUS_LOST;
      end else if (wid_thr < rcmix_pkg::WIDTH_MIN || wid_thr > rcmix_pkg::WIDTH_MAX
                   || wid_str < rcmix_pkg::WIDTH_MIN || wid_str > rcmix_pkg::WIDTH_MAX) begin
         r.status = rcmix_pkg::STATUS_RANGE;
      end else begin
         thr = shape_cmd(smooth_width(smooth_thr, wid_thr));
         str = shape_cmd(smooth_width(smooth_str, wid_str));
         lim = speed_r * 256;
         ramp_lin = slew(ramp_lin, thr, step_lin_r);
         ramp_trn = slew(ramp_trn, str, step_turn_r);
         turn = ramp_trn * gain_r;
         lft = ramp_lin * 256 + turn;
         rgt = ramp_lin * 256 - turn;
         ml = (lft < 0) ? -lft : lft;
         mr = (rgt < 0) ? -rgt : rgt;
         mag = (mr > ml) ? mr : ml;
         if (mag > lim) begin
            lft = lft * lim / mag;
            rgt = rgt * lim / mag;
         end
         held_l = lft;
         held_r = rgt;
         r.valid_res = 1'b1;
         r.status = rcmix_pkg::STATUS_OK;
      end
      r.left_wheel = held_l[23:0];
      r.right_wheel = held_r[23:0];
      wheel_results.push_back(r);
   endfunction

   // Request driver. Valid is raised only after a gap has run out, and it is held until
   // the transaction is accepted. Within one edge it is either kept high or changed once.
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
         req_gap <= 0;
      end else if (req_valid && req_ready) begin
         mix_predict(req_payload);
         n_accepted <= n_accepted + 1;
         req_gap = pick_gap();
         if (req_gap == 0 && pending_reqs.size() > 0) begin
            req_payload <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            req_payload <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Result monitor with random stalls on ready.
   int rsp_gap = 0;
   always @(posedge clock) begin
      rcmix_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (wheel_results.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               want = wheel_results.pop_front();
               if (rsp_payload.valid_res !== want.valid_res) begin
                  $error("valid_res expected %0d actual %0d", want.valid_res,
                         rsp_payload.valid_res);
                  errors++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_payload.status);
                  errors++;
               end
               if (rsp_payload.left_wheel !== want.left_wheel) begin
                  $error("left_wheel expected %0d actual %0d", want.left_wheel,
                         rsp_payload.left_wheel);
                  errors++;
               end
               if (rsp_payload.right_wheel !== want.right_wheel) begin
                  $error("right_wheel expected %0d actual %0d", want.right_wheel,
                         rsp_payload.right_wheel);
                  errors++;
               end
               if (want.valid_res) updates_ok++;
               else updates_failed++;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap <= pick_gap();
         end
      end
   end

   // The watchdog counts cycles in which neither channel accepts a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("rc_pwm_skid_steer_mixer_core regression: fail");
         $finish;
      end
   end

   // A register write is a setup phase followed by an access phase. The model is updated
   // at the same edge at which the block takes the write.
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= rcmix_pkg::PADDR_W'({idx, 2'b00}); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         rcmix_pkg::REG_TARGET_SPAN:  span_r = value[14:0];
         rcmix_pkg::REG_MAX_SPEED:    speed_r = value[14:0];
         rcmix_pkg::REG_DEAD_ZONE:    dead_r = value[14:0];
         rcmix_pkg::REG_RAMP_LINEAR:  step_lin_r = value[14:0];
         rcmix_pkg::REG_RAMP_TURN:    step_turn_r = value[14:0];
         rcmix_pkg::REG_MIX_GAIN:     gain_r = value[15:0];
         rcmix_pkg::REG_LOSS_TIMEOUT: timeout_r = value;
         default: ;
      endcase
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic write_all(logic [31:0] sp, logic [31:0] ms, logic [31:0] dz,
                            logic [31:0] rl, logic [31:0] rt, logic [31:0] mg,
                            logic [31:0] to);
      csr_write(rcmix_pkg::REG_TARGET_SPAN, sp);
      csr_write(rcmix_pkg::REG_MAX_SPEED, ms);
      csr_write(rcmix_pkg::REG_DEAD_ZONE, dz);
      csr_write(rcmix_pkg::REG_RAMP_LINEAR, rl);
      csr_write(rcmix_pkg::REG_RAMP_TURN, rt);
      csr_write(rcmix_pkg::REG_MIX_GAIN, mg);
      csr_write(rcmix_pkg::REG_LOSS_TIMEOUT, to);
   endtask

   // Waits until the queue is empty, no request is presented and every expected result has
   // come back, then lets the bench idle before it returns.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || wheel_results.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic void push_req(logic [1:0] m, logic lvl, logic [31:0] t);
      rcmix_pkg::req_type r;
      r.mode = m;
      r.pin_level = lvl;
      r.time_us = t;
      pending_reqs.push_back(r);
   endfunction

   // One full frame: a pulse on each channel followed by an update request.
   function automatic void push_frame(ref logic [31:0] now, input int w_thr,
                                      input int w_str);
      push_req(rcmix_pkg::MODE_THROTTLE, 1'b1, now);
      push_req(rcmix_pkg::MODE_THROTTLE, 1'b0, now + w_thr);
      push_req(rcmix_pkg::MODE_STEER, 1'b1, now + 10);
      push_req(rcmix_pkg::MODE_STEER, 1'b0, now + 10 + w_str);
      now = now + 10 + w_str + $urandom_range(0, 3000);
      push_req(rcmix_pkg::MODE_UPDATE, 1'($urandom_range(0, 1)), now);
      now = now + $urandom_range(100, 20000);
   endfunction

   function automatic int rand_width();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return $urandom_range(0, 899);
      if (r == 1) return $urandom_range(2101, 5000);
      if (r < 4) return (r == 2) ? rcmix_pkg::WIDTH_MIN : rcmix_pkg::WIDTH_MAX;
      return $urandom_range(950, 2050);
   endfunction

   // Random phase: mostly good frames, mixed with stray edges, unused mode and late
   // updates.
   task automatic random_phase(int n, logic [31:0] start);
      logic [31:0] now;
      int r;
      now = start;
      while (n > 0) begin
         r = $urandom_range(0, 19);
         if (r < 14) begin
            push_frame(now, rand_width(), rand_width());
            n -= 5;
         end else if (r < 16) begin
            push_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom());
            n -= 1;
         end else if (r < 18) begin
            now = now + $urandom_range(1, 300000);
            push_req(rcmix_pkg::MODE_UPDATE, 1'b0, now);
            n -= 1;
         end else begin
            push_req(2'd3, 1'($urandom_range(0, 1)), now);
            push_req(rcmix_pkg::MODE_UPDATE, 1'b0, now);
            n -= 2;
         end
      end
      drain();
   endtask

   initial begin
      logic [31:0] now;
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_valid = 1'b0; req_payload = '0; rsp_ready = 1'b0;
      model_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset settings: an update before any edge, widths at and
      // just past the range limits, a timeout, time wrap, and the unused mode.
      now = 32'd1000;
      push_req(rcmix_pkg::MODE_UPDATE, 1'b0, 32'd50);
      push_frame(now, rcmix_pkg::WIDTH_MIN, rcmix_pkg::WIDTH_MAX);
      push_frame(now, rcmix_pkg::WIDTH_MIN - 1, 1500);
      push_frame(now, 1500, rcmix_pkg::WIDTH_MAX + 1);
      push_req(2'd3, 1'b1, 32'hFFFF_FFFF);
      push_req(rcmix_pkg::MODE_UPDATE, 1'b1, now + 32'd200000);
      now = 32'hFFFF_F000;
      push_frame(now, 2000, 1000);
      push_frame(now, 1000, 2000);
      drain();

      // Extremes: zero speed limit, then largest span, speed and dead zone, the rest near zero.
      write_all(32'h0000_7FFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_7FFF,
                32'h0000_7FFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
      now = 32'h8000_0000;
      push_frame(now, 2100, 900);
      push_frame(now, 950, 2050);
      drain();
      write_all(32'hFFFF_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_0000,
                32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
      push_frame(now, 1500, 1500);
      now = 32'h1234_0000;
      push_req(rcmix_pkg::MODE_THROTTLE, 1'b1, now);
      push_req(rcmix_pkg::MODE_THROTTLE, 1'b0, now + 1500);
      push_req(rcmix_pkg::MODE_STEER, 1'b1, now);
      push_req(rcmix_pkg::MODE_STEER, 1'b0, now + 1501);
      push_req(rcmix_pkg::MODE_UPDATE, 1'b0, now + 1502);
      drain();

      // Random phases over several register settings. The mixer state carries over.
      write_all(32'(rcmix_pkg::RST_TARGET_SPAN), 32'(rcmix_pkg::RST_MAX_SPEED),
                32'(rcmix_pkg::RST_DEAD_ZONE), 32'(rcmix_pkg::RST_RAMP_LINEAR),
                32'(rcmix_pkg::RST_RAMP_TURN), 32'(rcmix_pkg::RST_MIX_GAIN),
                rcmix_pkg::RST_LOSS_TIMEOUT);
      random_phase(140, $urandom());
      write_all($urandom_range(0, 32767), $urandom_range(1, 32767), $urandom_range(0, 200),
                $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 65535),
                $urandom_range(20000, 400000));
      random_phase(140, $urandom());
      write_all(32'd4000, 32'd300, 32'd5, 32'd500, 32'd800, 32'd600, 32'd150000);
      random_phase(140, $urandom());
      write_all($urandom(), $urandom(), $urandom_range(0, 100), $urandom(), $urandom(),
                $urandom(), $urandom_range(1, 200000));
      random_phase(140, $urandom());

      $display("run covered %0d accepted transactions: %0d good updates, %0d rejected",
               n_accepted, updates_ok, updates_failed);
      if (errors == 0) begin
         $display("rc_pwm_skid_steer_mixer_core regression: pass");
      end else begin
         $display("rc_pwm_skid_steer_mixer_core regression: fail");
      end
      $finish;
   end

endmodule
